### design/gregorian_date_add_days_core_assert.svh
// Assertion macros shared by the date adder RTL.
// Each macro expects clk and rst_n to be visible in the including module.
`ifndef GREGORIAN_DATE_ADD_DAYS_CORE_ASSERT_SVH
`define GREGORIAN_DATE_ADD_DAYS_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GDAD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define GDAD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/gdad_pkg.sv
// Package for the Gregorian date adder: microcode word, status types and
// the month-length function. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package gdad_pkg;

    localparam int MonthW = 4;
    localparam int DayW   = 5;
    localparam int YearW  = 14;
    localparam int DaysW  = 16;

    // Quotient of year / 100 via multiply by reciprocal, exact for 14-bit years.
    localparam int DivMul   = 5243;
    localparam int DivShift = 19;
    localparam int QuotW    = 8;
    localparam int RemW     = 7;

    localparam logic [MonthW-1:0] MonthJan = 4'd1;
    localparam logic [MonthW-1:0] MonthFeb = 4'd2;
    localparam logic [MonthW-1:0] MonthDec = 4'd12;
    localparam logic [YearW-1:0]  YearMax  = 14'd16383;
    localparam logic [RemW-1:0]   RemLast  = 7'd99;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_LOAD,
        OP_DIV,
        OP_REM,
        OP_CHECK,
        OP_STEP,
        OP_OUT
    } op_t;

    typedef enum logic [2:0] {
        C_ALWAYS,
        C_NO_IN,
        C_BAD,
        C_LEFT_NZ,
        C_OUT_FULL
    } cond_t;

    typedef logic [2:0] step_t;

    localparam step_t STEP_IDLE  = 3'd0;
    localparam step_t STEP_DIV   = 3'd1;
    localparam step_t STEP_REM   = 3'd2;
    localparam step_t STEP_CHECK = 3'd3;
    localparam step_t STEP_WALK  = 3'd4;
    localparam step_t STEP_OUT   = 3'd5;

    // Jump to jmp when cond holds, otherwise continue at nxt.
    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t jmp;
        step_t nxt;
    } uword_t;

    typedef struct packed {
        logic bad;
        logic left_nz;
        logic out_full;
    } stat_t;

    // Days in a month; zero for a month code outside January..December.
    function automatic logic [DayW-1:0] month_days(input logic [MonthW-1:0] m,
                                                   input logic leap);
        logic [DayW-1:0] len;
        begin
            case (m)
                4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
                4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
                4'd2:                                        len = leap ? 5'd29 : 5'd28;
                default:                                     len = 5'd0;
            endcase
            return len;
        end
    endfunction

endpackage

`default_nettype wire

### design/gdad_ucode.sv
// Microcode ROM of the date adder: one control word per sequencer step.
// Depends on gdad_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gdad_ucode (
    input  wire gdad_pkg::step_t step,
    output gdad_pkg::uword_t     word
);
    import gdad_pkg::*;

    always_comb
    begin
        case (step)
            STEP_IDLE:  word = '{op: OP_LOAD,  cond: C_NO_IN,    jmp: STEP_IDLE,  nxt: STEP_DIV};
            STEP_DIV:   word = '{op: OP_DIV,   cond: C_ALWAYS,   jmp: STEP_REM,   nxt: STEP_REM};
            STEP_REM:   word = '{op: OP_REM,   cond: C_ALWAYS,   jmp: STEP_CHECK, nxt: STEP_CHECK};
            STEP_CHECK: word = '{op: OP_CHECK, cond: C_BAD,      jmp: STEP_OUT,   nxt: STEP_WALK};
            STEP_WALK:  word = '{op: OP_STEP,  cond: C_LEFT_NZ,  jmp: STEP_WALK,  nxt: STEP_OUT};
            STEP_OUT:   word = '{op: OP_OUT,   cond: C_OUT_FULL, jmp: STEP_OUT,   nxt: STEP_IDLE};
            default:    word = '{op: OP_NOP,   cond: C_ALWAYS,   jmp: STEP_IDLE,  nxt: STEP_IDLE};
        endcase
    end

endmodule

`default_nettype wire

### design/gdad_datapath.sv
// Datapath of the date adder: date registers, leap-year tracking, month walk
// and output register. Depends on gdad_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "gregorian_date_add_days_core_assert.svh"

module gdad_datapath (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire gdad_pkg::op_t             op,
    input  wire logic                      in_valid,
    input  wire logic [gdad_pkg::MonthW-1:0] start_month,
    input  wire logic [gdad_pkg::DayW-1:0]   start_day,
    input  wire logic [gdad_pkg::YearW-1:0]  start_year,
    input  wire logic [gdad_pkg::DaysW-1:0]  days_to_add,
    input  wire logic                      out_stall,
    output logic                           out_valid,
    output logic [gdad_pkg::MonthW-1:0]    new_month,
    output logic [gdad_pkg::DayW-1:0]      new_day,
    output logic [gdad_pkg::YearW-1:0]     new_year,
    output logic                           bad_date,
    output gdad_pkg::stat_t                stat
);
    import gdad_pkg::*;

    localparam int ProdW = YearW + 13;

    logic [MonthW-1:0] m_reg, m_next;
    logic [DayW-1:0]   d_reg, d_next;
    logic [YearW-1:0]  y_reg, y_next;
    logic [DaysW-1:0]  left_reg, left_next;
    logic [QuotW-1:0]  q_reg, q_next;
    logic [RemW-1:0]   rem100_reg, rem100_next;
    logic [1:0]        q4_reg, q4_next;
    logic              bad_reg, bad_next;
    logic              out_valid_reg, out_valid_next;

    logic [ProdW-1:0]  prod;
    logic [YearW:0]    q_times_100;
    logic [YearW:0]    rem_full;
    logic              leap;
    logic [DayW-1:0]   len;
    logic [DayW-1:0]   room;
    logic              invalid;
    logic              out_full;
    logic              walking;
    logic              walk_sane;

    assign prod        = ProdW'(y_reg) * ProdW'(DivMul);
    assign q_times_100 = ({7'd0, q_reg} << 6) + ({7'd0, q_reg} << 5) + ({7'd0, q_reg} << 2);
    assign rem_full    = {1'b0, y_reg} - q_times_100;

    // Divisible by 4, and either not by 100 or also by 400.
    assign leap    = (y_reg[1:0] == 2'd0) && ((rem100_reg != '0) || (q4_reg == 2'd0));
    assign len     = month_days(m_reg, leap);
    assign room    = len - d_reg;
    assign invalid = (len == '0) || (d_reg == '0) || (d_reg > len);

    assign out_full = out_valid_reg && out_stall;

    always_comb
    begin
        m_next      = m_reg;
        d_next      = d_reg;
        y_next      = y_reg;
        left_next   = left_reg;
        q_next      = q_reg;
        rem100_next = rem100_reg;
        q4_next     = q4_reg;
        bad_next    = bad_reg;
        case (op)
            OP_LOAD:
            begin
                if (in_valid)
                begin
                    m_next    = start_month;
                    d_next    = start_day;
                    y_next    = start_year;
                    left_next = days_to_add;
                end
            end
            OP_DIV:
            begin
                q_next = prod[DivShift +: QuotW];
            end
            OP_REM:
            begin
                rem100_next = rem_full[RemW-1:0];
                q4_next     = q_reg[1:0];
            end
            OP_CHECK:
            begin
                bad_next = invalid;
            end
            OP_STEP:
            begin
                if (left_reg != '0)
                begin
                    if (left_reg > DaysW'(room))
                    begin
                        left_next = left_reg - DaysW'(room) - DaysW'(1);
                        d_next    = DayW'(1);
                        if (m_reg == MonthDec)
                        begin
                            m_next = MonthJan;
                            y_next = y_reg + YearW'(1);
                            // The year counter wraps to zero, which restarts the century count.
                            if (y_reg == YearMax)
                            begin
                                rem100_next = '0;
                                q4_next     = '0;
                            end
                            else if (rem100_reg == RemLast)
                            begin
                                rem100_next = '0;
                                q4_next     = q4_reg + 2'd1;
                            end
                            else
                            begin
                                rem100_next = rem100_reg + RemW'(1);
                            end
                        end
                        else
                        begin
                            m_next = m_reg + MonthW'(1);
                        end
                    end
                    else
                    begin
                        d_next    = d_reg + left_reg[DayW-1:0];
                        left_next = '0;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if ((op == OP_OUT) && !out_full)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg      <= m_next;
        d_reg      <= d_next;
        y_reg      <= y_next;
        left_reg   <= left_next;
        q_reg      <= q_next;
        rem100_reg <= rem100_next;
        q4_reg     <= q4_next;
        bad_reg    <= bad_next;
        if ((op == OP_OUT) && !out_full)
        begin
            new_month <= m_reg;
            new_day   <= d_reg;
            new_year  <= y_reg;
            bad_date  <= bad_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign stat      = '{bad: invalid, left_nz: (left_reg != '0), out_full: out_full};

    assign walking   = (op == OP_STEP) && (left_reg != '0);
    assign walk_sane = (m_reg >= MonthJan) && (m_reg <= MonthDec) && (d_reg != '0)
                       && (rem100_reg <= RemLast);

    `GDAD_ASSERT_NOW(a_walk_range, walking, walk_sane, "walk state out of range")
    `GDAD_ASSERT_NOW(a_day_fits, walking, d_reg <= len, "day beyond month length during walk")
    `GDAD_ASSERT_NEXT(a_left_shrinks, walking, left_reg < $past(left_reg), "day count stuck")

endmodule

`default_nettype wire

### design/gregorian_date_add_days_core.sv
// Gregorian date adder, top level. The sequencer loads the input beat, divides the year
// by 100, takes the remainder, checks the date and, for a valid date, walks month by month
// through the days to add before the output step; an invalid date goes straight to the
// output step. One item at a time; the next input beat is taken once the result sits
// in the output register.
// Reset clears the step counter and the output valid.
`timescale 1ns / 1ps
`default_nettype none

module gregorian_date_add_days_core (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic [gdad_pkg::MonthW-1:0] start_month,
    input  wire logic [gdad_pkg::DayW-1:0]   start_day,
    input  wire logic [gdad_pkg::YearW-1:0]  start_year,
    input  wire logic [gdad_pkg::DaysW-1:0]  days_to_add,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic [gdad_pkg::MonthW-1:0]      new_month,
    output logic [gdad_pkg::DayW-1:0]        new_day,
    output logic [gdad_pkg::YearW-1:0]       new_year,
    output logic                             bad_date
);
    import gdad_pkg::*;

    step_t  step_reg, step_next;
    uword_t word;
    stat_t  stat;
    logic   jump;

    gdad_ucode u_ucode (
        .step (step_reg),
        .word (word)
    );

    gdad_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .op          (word.op),
        .in_valid    (in_valid),
        .start_month (start_month),
        .start_day   (start_day),
        .start_year  (start_year),
        .days_to_add (days_to_add),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .new_month   (new_month),
        .new_day     (new_day),
        .new_year    (new_year),
        .bad_date    (bad_date),
        .stat        (stat)
    );

    always_comb
    begin
        case (word.cond)
            C_ALWAYS:   jump = 1'b1;
            C_NO_IN:    jump = !in_valid;
            C_BAD:      jump = stat.bad;
            C_LEFT_NZ:  jump = stat.left_nz;
            C_OUT_FULL: jump = stat.out_full;
            default:    jump = 1'b1;
        endcase
    end

    assign step_next = jump ? word.jmp : word.nxt;
    assign in_stall  = (word.op != OP_LOAD);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

`default_nettype wire
